### src/hbridge_timed_command_queue_top_macros.svh
// Assertion macros shared by the H-bridge command queue RTL.
`ifndef HBRIDGE_TIMED_COMMAND_QUEUE_TOP_MACROS_SVH
`define HBRIDGE_TIMED_COMMAND_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define HBTCQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hbtcq same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset
`define HBTCQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hbtcq next-cycle check failed");

`endif

### src/hbtcq_pkg.sv
// Shared constants and types for the H-bridge timed command queue.
package hbtcq_pkg;

  // queue geometry
  localparam int QUEUE_SLOTS = 4;

  // field widths
  localparam int KIND_W   = 2;
  localparam int STATE_W  = 2;
  localparam int LENGTH_W = 16;
  localparam int TIME_W   = 32;
  localparam int LED_W    = 8;
  localparam int MODE_W   = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  // fixed pulse length of push / unpush entries
  localparam logic [LENGTH_W-1:0] PUSH_PULSE_MS = 16'd50;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNPUSH = 2'd3;

  // bridge states
  localparam logic [STATE_W-1:0] BR_OFF     = 2'd0;
  localparam logic [STATE_W-1:0] BR_LEFT    = 2'd1;
  localparam logic [STATE_W-1:0] BR_RIGHT   = 2'd2;
  localparam logic [STATE_W-1:0] BR_INVALID = 2'd3;

  // indicator modes
  localparam logic [MODE_W-1:0] LED_NONE   = 2'd0;
  localparam logic [MODE_W-1:0] LED_BINARY = 2'd1;
  localparam logic [MODE_W-1:0] LED_PWM    = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LED_MODE       = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LED_BRIGHTNESS = 1'd1;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic                enq;
    logic                fire;
    logic [STATE_W-1:0]  wr_state;
    logic [LENGTH_W-1:0] wr_length;
    logic [TIME_W-1:0]   wr_start;
    logic [TIME_W-1:0]   now;
  } cell_ctrl_t;

  // word handed from one cell to the next
  typedef struct packed {
    logic                free_seen;
    logic                due_seen;
    logic [STATE_W-1:0]  due_state;
    logic [LENGTH_W-1:0] due_length;
  } cell_link_t;

endpackage

### src/hbtcq_cell.sv
// One queue slot: holds a timed command and takes part in the free and due chains.
module hbtcq_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  hbtcq_pkg::cell_ctrl_t  ctrl,
  input  hbtcq_pkg::cell_link_t  link_in,
  output hbtcq_pkg::cell_link_t  link_out,
  output logic                   claim
);

  logic                          busy;
  logic [hbtcq_pkg::STATE_W-1:0] slot_state;
  logic [hbtcq_pkg::LENGTH_W-1:0] slot_length;
  logic [hbtcq_pkg::TIME_W-1:0]  slot_start;
  logic                          due;
  logic                          fire_here;

  // this slot is due when it holds a command whose start has come
  assign due       = busy && (slot_start <= ctrl.now);
  assign claim     = ctrl.enq && !busy && !link_in.free_seen;
  assign fire_here = ctrl.fire && due && !link_in.due_seen;

  // pass the chain on: the first free and the first due slot win
  always_comb begin
    link_out.free_seen  = link_in.free_seen || !busy;
    link_out.due_seen   = link_in.due_seen || due;
    link_out.due_state  = fire_here ? slot_state  : link_in.due_state;
    link_out.due_length = fire_here ? slot_length : link_in.due_length;
  end

  // busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (claim) begin
      busy <= 1'b1;
    end else if (fire_here) begin
      busy <= 1'b0;
    end
  end

  // slot payload, written on claim only
  always_ff @(posedge clk) begin
    if (claim) begin
      slot_state  <= ctrl.wr_state;
      slot_length <= ctrl.wr_length;
      slot_start  <= ctrl.wr_start;
    end
  end

endmodule

### src/hbridge_timed_command_queue_top.sv
// Top level: item sequencer, bridge and indicator state, and the row of queue cells.
// Path: a tick or a set runs S_TICK or S_ENQ1, then S_LOAD; a push or unpush runs S_ENQ1,
// S_ENQ2, then S_LOAD, which holds while the result waits for m_tready.
// Throughput: the sequencer handles one item at a time, taking the next only in S_IDLE,
// and a push writes its two entries through the cell row on consecutive cycles.
// Reset (rst, synchronous): counter, revert time, bridge state, indicator, registers
// and all slot busy flags clear together; no clearing pass.
module hbridge_timed_command_queue_top (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // target_state[1:0], pulse_length[17:2], push_delay[33:18]
  input  logic [1:0]  s_tuser,  // kind[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // pin_a[0], pin_b[1], led_level[9:2], bridge_state[11:10],
                                // state_changed[12], accepted[13]
  // configuration
  input  logic                                cfg_we,
  input  logic [hbtcq_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [hbtcq_pkg::CFG_DATA_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ1,
    S_ENQ2,
    S_TICK,
    S_LOAD
  } seq_state_t;

  seq_state_t state;

  // latched item
  logic [hbtcq_pkg::KIND_W-1:0]   kind;
  logic [hbtcq_pkg::STATE_W-1:0]  target_state;
  logic [hbtcq_pkg::LENGTH_W-1:0] pulse_length;
  logic [hbtcq_pkg::LENGTH_W-1:0] push_delay;

  // block state
  logic [hbtcq_pkg::TIME_W-1:0]  now_ms;
  logic [hbtcq_pkg::TIME_W-1:0]  revert_time;
  logic [hbtcq_pkg::STATE_W-1:0] current_state;
  logic [hbtcq_pkg::LED_W-1:0]   led_register;
  logic [hbtcq_pkg::MODE_W-1:0]  led_mode;
  logic [hbtcq_pkg::LED_W-1:0]   led_brightness;
  logic                          state_changed;
  logic                          accepted;

  // cell row
  hbtcq_pkg::cell_ctrl_t ctrl;
  hbtcq_pkg::cell_link_t link [hbtcq_pkg::QUEUE_SLOTS+1];
  logic [hbtcq_pkg::QUEUE_SLOTS-1:0] claim;

  logic                          set_ok;
  logic                          revert_hit;
  logic                          out_free;
  logic [hbtcq_pkg::STATE_W-1:0] apply_st;
  logic                          apply_en;
  logic [hbtcq_pkg::LED_W-1:0]   led_register_next;

  assign s_tready   = (state == S_IDLE);
  assign out_free   = !m_tvalid || m_tready;
  assign set_ok     = (target_state != hbtcq_pkg::BR_INVALID);
  assign revert_hit = (revert_time != '0) && (now_ms > revert_time);

  // control broadcast to the cells
  always_comb begin
    ctrl.enq       = 1'b0;
    ctrl.fire      = (state == S_TICK) && !revert_hit;
    ctrl.wr_state  = hbtcq_pkg::BR_RIGHT;
    ctrl.wr_length = hbtcq_pkg::PUSH_PULSE_MS;
    ctrl.wr_start  = now_ms + hbtcq_pkg::TIME_W'(1);
    ctrl.now       = now_ms;
    case (state)
      S_ENQ1: begin
        if (kind == hbtcq_pkg::KIND_SET) begin
          ctrl.enq       = set_ok;
          ctrl.wr_state  = target_state;
          ctrl.wr_length = pulse_length;
        end else begin
          ctrl.enq      = 1'b1;
          ctrl.wr_state = (kind == hbtcq_pkg::KIND_PUSH) ? hbtcq_pkg::BR_RIGHT
                                                         : hbtcq_pkg::BR_LEFT;
        end
      end
      S_ENQ2: begin
        ctrl.enq      = 1'b1;
        ctrl.wr_state = (kind == hbtcq_pkg::KIND_PUSH) ? hbtcq_pkg::BR_LEFT
                                                       : hbtcq_pkg::BR_RIGHT;
        ctrl.wr_start = now_ms + {{(hbtcq_pkg::TIME_W-hbtcq_pkg::LENGTH_W){1'b0}}, push_delay}
                        + hbtcq_pkg::TIME_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign link[0] = '0;

  // row of slot cells
  for (genvar i = 0; i < hbtcq_pkg::QUEUE_SLOTS; i++) begin : g_cell
    hbtcq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .claim    (claim[i])
    );
  end

  // state application on a tick
  always_comb begin
    apply_en = 1'b0;
    apply_st = hbtcq_pkg::BR_OFF;
    if (state == S_TICK) begin
      if (revert_hit) begin
        apply_en = 1'b1;
      end else if (link[hbtcq_pkg::QUEUE_SLOTS].due_seen) begin
        apply_en = 1'b1;
        apply_st = link[hbtcq_pkg::QUEUE_SLOTS].due_state;
      end
    end
  end

  // indicator update for the applied state
  always_comb begin
    led_register_next = led_register;
    if (apply_st == hbtcq_pkg::BR_LEFT) begin
      if (led_mode == hbtcq_pkg::LED_BINARY || led_mode == hbtcq_pkg::LED_PWM) begin
        led_register_next = '0;
      end
    end else if (apply_st == hbtcq_pkg::BR_RIGHT) begin
      if (led_mode == hbtcq_pkg::LED_BINARY) begin
        led_register_next = hbtcq_pkg::LED_W'(1);
      end else if (led_mode == hbtcq_pkg::LED_PWM) begin
        led_register_next = led_brightness;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      led_mode       <= hbtcq_pkg::LED_NONE;
      led_brightness <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        hbtcq_pkg::REG_LED_MODE:       led_mode <= cfg_data[hbtcq_pkg::MODE_W-1:0];
        hbtcq_pkg::REG_LED_BRIGHTNESS: led_brightness <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input word latch
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      kind         <= s_tuser;
      target_state <= s_tdata[1:0];
      pulse_length <= s_tdata[17:2];
      push_delay   <= s_tdata[33:18];
    end
  end

  // sequencer, block state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      now_ms        <= '0;
      revert_time   <= '0;
      current_state <= hbtcq_pkg::BR_OFF;
      led_register  <= '0;
      state_changed <= 1'b0;
      accepted      <= 1'b0;
      m_tvalid      <= 1'b0;
      m_tdata       <= '0;
    end else begin
      // result word taken; S_LOAD reloads it in the same cycle instead
      if (m_tvalid && m_tready && state != S_LOAD) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state_changed <= 1'b0;
            accepted      <= 1'b0;
            if (s_tuser == hbtcq_pkg::KIND_TICK) begin
              now_ms <= now_ms + hbtcq_pkg::TIME_W'(1);
              state  <= S_TICK;
            end else begin
              state <= S_ENQ1;
            end
          end
        end
        S_ENQ1: begin
          accepted <= ctrl.enq && !link[hbtcq_pkg::QUEUE_SLOTS].free_seen ? 1'b0 :
                      ctrl.enq;
          state    <= (kind == hbtcq_pkg::KIND_SET) ? S_LOAD : S_ENQ2;
        end
        S_ENQ2: begin
          accepted <= accepted && link[hbtcq_pkg::QUEUE_SLOTS].free_seen;
          state    <= S_LOAD;
        end
        S_TICK: begin
          if (revert_hit) begin
            revert_time <= '0;
          end else if (link[hbtcq_pkg::QUEUE_SLOTS].due_seen &&
                       link[hbtcq_pkg::QUEUE_SLOTS].due_length != '0) begin
            revert_time <= now_ms + {{(hbtcq_pkg::TIME_W-hbtcq_pkg::LENGTH_W){1'b0}},
                                     link[hbtcq_pkg::QUEUE_SLOTS].due_length};
          end
          if (apply_en) begin
            current_state <= apply_st;
            led_register  <= led_register_next;
            state_changed <= 1'b1;
          end
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            m_tvalid      <= 1'b1;
            m_tdata[0]    <= (current_state == hbtcq_pkg::BR_RIGHT);
            m_tdata[1]    <= (current_state == hbtcq_pkg::BR_LEFT);
            m_tdata[9:2]  <= led_register;
            m_tdata[11:10] <= current_state;
            m_tdata[12]   <= state_changed;
            m_tdata[13]   <= accepted;
            m_tdata[15:14] <= '0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `include "hbridge_timed_command_queue_top_macros.svh"

  `HBTCQ_ASSERT_NOW(a_one_claim, 1'b1, $onehot0(claim))
  `HBTCQ_ASSERT_NOW(a_no_enq_and_fire, ctrl.enq, !ctrl.fire)
  `HBTCQ_ASSERT_NOW(a_state_valid, 1'b1, current_state != hbtcq_pkg::BR_INVALID)
  `HBTCQ_ASSERT_NEXT(a_accept_leaves_idle, s_tvalid && s_tready, state != S_IDLE)

endmodule
